FILE: design/csh_pkg.sv
// ----------------------------------------------------------------------------
// csh_pkg
// Types and fixed constants shared by the histogrammer modules.
// ----------------------------------------------------------------------------
package csh_pkg;

    typedef enum logic [1:0] {
        OP_COUNT = 2'd0,
        OP_LOAD  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    localparam logic [2:0] KIND_OLD_E = 3'd0;
    localparam logic [2:0] KIND_OLD_T = 3'd1;
    localparam logic [2:0] KIND_NEW_E = 3'd2;
    localparam logic [2:0] KIND_NEW_T = 3'd3;
    localparam logic [2:0] KIND_GE    = 3'd4;

    localparam logic [2:0] TSEL_NA_GAIN   = 3'd0;
    localparam logic [2:0] TSEL_NA_SHIFT  = 3'd1;
    localparam logic [2:0] TSEL_NA_TSHIFT = 3'd2;
    localparam logic [2:0] TSEL_GE_GAIN   = 3'd3;
    localparam logic [2:0] TSEL_GE_SHIFT  = 3'd4;

    localparam logic [2:0] ST_COUNTED = 3'd0;
    localparam logic [2:0] ST_CLIPPED = 3'd1;
    localparam logic [2:0] ST_IGNORED = 3'd2;
    localparam logic [2:0] ST_DONE    = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    localparam logic [15:0] UNITY_GAIN = 16'd16384;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_MUL,
        S_ADD,
        S_SUM,
        S_RD,
        S_WAIT,
        S_WR
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_step;  // write zero at the sweep address and advance
        logic capture;     // latch the input transaction
        logic mul;         // register the product
        logic sum;         // form bin and address
        logic rd;          // issue the store read
        logic wr;          // write back and present the result
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic needs_store;  // transaction touches the histogram store
        logic needs_mul;    // transaction goes through the calibration path
    } stat_t;

endpackage

FILE: design/calibrated_spectrum_histogrammer_unit.sv
// ----------------------------------------------------------------------------
// calibrated_spectrum_histogrammer_unit
// Calibrated pulse-height histogrammer with a single-port histogram store.
// ----------------------------------------------------------------------------
// Channel   Handshake        Ports
// command   start / busy     operation kind channel raw_value dither bin_index
//                            table_select cal_value event_last
// result    done (strobe)    status kind_out channel_out bin_out count_out
//                            event_last_out
//
// A transaction goes from the accepting state to MUL, then straight to WR when
// it reaches no bin, or through RD and WAIT to WR when it reads, clears or
// updates a bin; a bin of the new energy spectrum or of an even germanium
// channel also passes ADD and SUM before RD, as the product and its offset sum
// each have a register stage. Busy falls in the result cycle. After reset the
// store is cleared one word a cycle, with busy high until the sweep ends.
// The receiver cannot stall: done is high for one cycle per transaction.
module calibrated_spectrum_histogrammer_unit #(
    parameter int CHANNELS    = 32,
    parameter int GE_CHANNELS = 16,
    parameter int ENERGY_BINS = 2048,
    parameter int TIME_BINS   = 512,
    parameter int GE_BINS     = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [2:0]         kind,
    input  logic [4:0]         channel,
    input  logic [15:0]        raw_value,
    input  logic signed [7:0]  dither,
    input  logic [11:0]        bin_index,
    input  logic [2:0]         table_select,
    input  logic signed [16:0] cal_value,
    input  logic               event_last,
    output logic               done,
    output logic [2:0]         status,
    output logic [2:0]         kind_out,
    output logic [4:0]         channel_out,
    output logic [11:0]        bin_out,
    output logic [31:0]        count_out,
    output logic               event_last_out
);

    csh_pkg::cmd_t  cmd;
    csh_pkg::stat_t stat;

    csh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    csh_datapath #(
        .CHANNELS    (CHANNELS),
        .GE_CHANNELS (GE_CHANNELS),
        .ENERGY_BINS (ENERGY_BINS),
        .TIME_BINS   (TIME_BINS),
        .GE_BINS     (GE_BINS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .operation      (operation),
        .kind           (kind),
        .channel        (channel),
        .raw_value      (raw_value),
        .dither         (dither),
        .bin_index      (bin_index),
        .table_select   (table_select),
        .cal_value      (cal_value),
        .event_last     (event_last),
        .done           (done),
        .status         (status),
        .kind_out       (kind_out),
        .channel_out    (channel_out),
        .bin_out        (bin_out),
        .count_out      (count_out),
        .event_last_out (event_last_out)
    );

endmodule

FILE: design/csh_ram.sv
// ----------------------------------------------------------------------------
// csh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module csh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: design/csh_ctrl.sv
// ----------------------------------------------------------------------------
// csh_ctrl
// Controller: store clearing sweep after reset, then one transaction at a time.
// ----------------------------------------------------------------------------
module csh_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  csh_pkg::stat_t stat,
    output logic           busy,
    output csh_pkg::cmd_t  cmd
);

    csh_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csh_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csh_pkg::S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = csh_pkg::S_IDLE;
                end
            end
            csh_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = csh_pkg::S_MUL;
                end
            end
            csh_pkg::S_MUL:
            begin
                if (!stat.needs_store)
                begin
                    state_next = csh_pkg::S_WR;
                end
                else
                begin
                    state_next = stat.needs_mul ? csh_pkg::S_ADD : csh_pkg::S_RD;
                end
            end
            csh_pkg::S_ADD:  state_next = csh_pkg::S_SUM;
            csh_pkg::S_SUM:  state_next = csh_pkg::S_RD;
            csh_pkg::S_RD:   state_next = csh_pkg::S_WAIT;
            csh_pkg::S_WAIT: state_next = csh_pkg::S_WR;
            csh_pkg::S_WR:   state_next = csh_pkg::S_IDLE;
            default:         state_next = csh_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            csh_pkg::S_CLEAR: cmd.clear_step = 1'b1;
            csh_pkg::S_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            csh_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
                // Uncalibrated paths that reach the store form the bin directly.
                cmd.sum = stat.needs_store && !stat.needs_mul;
            end
            // The product plus its offsets is registered in this cycle.
            csh_pkg::S_ADD:  cmd = '0;
            csh_pkg::S_SUM:  cmd.sum = 1'b1;
            csh_pkg::S_RD:   cmd.rd = 1'b1;
            csh_pkg::S_WAIT: cmd.rd = 1'b0;
            csh_pkg::S_WR:   cmd.wr = 1'b1;
            default:         cmd = '0;
        endcase
    end

endmodule

FILE: design/csh_datapath.sv
// ----------------------------------------------------------------------------
// csh_datapath
// Calibration tables, bin arithmetic and the histogram store.
// ----------------------------------------------------------------------------
module csh_datapath #(
    parameter int CHANNELS    = 32,
    parameter int GE_CHANNELS = 16,
    parameter int ENERGY_BINS = 2048,
    parameter int TIME_BINS   = 512,
    parameter int GE_BINS     = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  csh_pkg::cmd_t       cmd,
    output csh_pkg::stat_t      stat,
    input  logic [1:0]          operation,
    input  logic [2:0]          kind,
    input  logic [4:0]          channel,
    input  logic [15:0]         raw_value,
    input  logic signed [7:0]   dither,
    input  logic [11:0]         bin_index,
    input  logic [2:0]          table_select,
    input  logic signed [16:0]  cal_value,
    input  logic                event_last,
    output logic                done,
    output logic [2:0]          status,
    output logic [2:0]          kind_out,
    output logic [4:0]          channel_out,
    output logic [11:0]         bin_out,
    output logic [31:0]         count_out,
    output logic                event_last_out
);

    localparam int REG_OLD_T   = CHANNELS * ENERGY_BINS;
    localparam int REG_NEW_E   = REG_OLD_T + CHANNELS * TIME_BINS;
    localparam int REG_NEW_T   = REG_NEW_E + CHANNELS * ENERGY_BINS;
    localparam int REG_GE_E    = REG_NEW_T + CHANNELS * TIME_BINS;
    localparam int REG_GE_T    = REG_GE_E + GE_CHANNELS * GE_BINS;
    localparam int STORE_DEPTH = REG_GE_T + GE_CHANNELS * TIME_BINS;
    localparam int AW          = $clog2(STORE_DEPTH);
    // The channel port is five bits wide, so no more than 32 entries are reachable.
    localparam int CHW         = (CHANNELS > 32) ? 5
                               : ((CHANNELS > 1) ? $clog2(CHANNELS) : 1);
    localparam int GCHW        = $clog2(GE_CHANNELS);

    // Calibration tables (small, reset to their defaults).
    logic [15:0]        na_gain_reg   [CHANNELS];
    logic signed [16:0] na_shift_reg  [CHANNELS];
    logic signed [16:0] na_tshift_reg [CHANNELS];
    logic [15:0]        ge_gain_reg   [GE_CHANNELS];
    logic signed [16:0] ge_shift_reg  [GE_CHANNELS];

    // Captured transaction.
    logic [1:0]         op_reg;
    logic [2:0]         kind_reg;
    logic [4:0]         ch_reg;
    logic [11:0]        bidx_reg;
    logic [2:0]         tsel_reg;
    logic signed [16:0] cal_reg;
    logic               last_reg;
    logic signed [24:0] v_reg;
    logic [15:0]        gain_reg;
    logic signed [16:0] shift_reg;

    logic signed [41:0] prod_reg;
    logic signed [47:0] t_reg;
    logic [AW-1:0]      addr_reg;
    logic [11:0]        bin_reg;
    logic [2:0]         st_reg;
    logic               rmw_reg;
    logic [AW-1:0]      clr_reg;
    logic               clr_done_reg;

    logic [31:0] rdata;
    logic [5:0]  ch6;

    assign ch6 = {1'b0, ch_reg};

    // Region checks on the captured transaction.
    logic na_ok, ge_ok, loc_ok;
    logic [14:0] nbins;
    logic [AW-1:0] base;

    always_comb
    begin
        na_ok  = {1'b0, ch6} < 7'(CHANNELS);
        ge_ok  = ch6 < 6'(GE_CHANNELS);
        loc_ok = 1'b0;
        nbins  = '0;
        base   = '0;
        case (kind_reg)
            csh_pkg::KIND_OLD_E, csh_pkg::KIND_NEW_E:
            begin
                loc_ok = na_ok;
                nbins  = 15'(ENERGY_BINS);
                base   = AW'((kind_reg == csh_pkg::KIND_OLD_E ? 0 : REG_NEW_E))
                         + AW'(ch_reg) * AW'(ENERGY_BINS);
            end
            csh_pkg::KIND_OLD_T, csh_pkg::KIND_NEW_T:
            begin
                loc_ok = na_ok;
                nbins  = 15'(TIME_BINS);
                base   = AW'((kind_reg == csh_pkg::KIND_OLD_T ? REG_OLD_T : REG_NEW_T))
                         + AW'(ch_reg) * AW'(TIME_BINS);
            end
            csh_pkg::KIND_GE:
            begin
                loc_ok = ge_ok;
                if (!ch_reg[0])
                begin
                    nbins = 15'(GE_BINS);
                    base  = AW'(REG_GE_E) + AW'(ch_reg) * AW'(GE_BINS);
                end
                else
                begin
                    nbins = 15'(TIME_BINS);
                    base  = AW'(REG_GE_T) + AW'(ch_reg) * AW'(TIME_BINS);
                end
            end
            default: loc_ok = 1'b0;
        endcase
    end

    logic count_ok, calib;
    assign count_ok = loc_ok && !(kind_reg == csh_pkg::KIND_GE && ch_reg < 5'd4);
    assign calib    = (kind_reg == csh_pkg::KIND_NEW_E)
                   || (kind_reg == csh_pkg::KIND_GE && !ch_reg[0]);

    always_comb
    begin
        stat.clear_done  = clr_done_reg;
        stat.needs_mul   = calib;
        case (op_reg)
            csh_pkg::OP_COUNT: stat.needs_store = count_ok;
            csh_pkg::OP_LOAD:  stat.needs_store = 1'b0;
            default:           stat.needs_store = loc_ok && ({3'b0, bidx_reg} < nbins);
        endcase
    end

    // Offset term and divisor shift for the count path; t is formed then
    // divided toward zero by a power of two.
    logic signed [47:0] t_comb;
    logic [4:0]         sh;
    logic signed [47:0] q;
    logic signed [47:0] mag;

    always_comb
    begin
        t_comb = '0;
        sh     = 5'd9;
        case (kind_reg)
            csh_pkg::KIND_OLD_E:
            begin
                t_comb = 48'(v_reg);
                sh     = 5'd9;
            end
            csh_pkg::KIND_OLD_T:
            begin
                t_comb = 48'(v_reg);
                sh     = 5'd12;
            end
            csh_pkg::KIND_NEW_E:
            begin
                t_comb = 48'(prod_reg) + (48'(shift_reg) <<< 19) + 48'sd4194304;
                sh     = 5'd23;
            end
            csh_pkg::KIND_NEW_T:
            begin
                t_comb = 48'(v_reg) + (48'(shift_reg) <<< 8) + 48'sd2048;
                sh     = 5'd12;
            end
            default:
            begin
                if (!ch_reg[0])
                begin
                    t_comb = 48'(prod_reg) + (48'(shift_reg) <<< 18) + 48'sd2097152;
                    sh     = 5'd22;
                end
                else
                begin
                    t_comb = 48'(v_reg) + (48'(shift_reg) <<< 7) + 48'sd1024;
                    sh     = 5'd11;
                end
            end
        endcase
    end

    logic signed [47:0] t_use;
    assign t_use = calib ? t_reg : t_comb;

    always_comb
    begin
        mag = t_use[47] ? -t_use : t_use;
        q   = 48'(mag >> sh);
        if (t_use[47])
        begin
            q = -q;
        end
    end

    logic bin_bad;
    assign bin_bad = q[47] || (q > 48'(nbins) - 48'sd1);

    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [31:0]   ram_wdata;

    always_comb
    begin
        ram_addr  = addr_reg;
        ram_we    = 1'b0;
        ram_wdata = rdata + 32'd1;
        if (cmd.clear_step)
        begin
            ram_addr  = clr_reg;
            ram_we    = !clr_done_reg;
            ram_wdata = '0;
        end
        else if (cmd.wr && rmw_reg)
        begin
            ram_we = 1'b1;
            if (op_reg == csh_pkg::OP_CLEAR)
            begin
                ram_wdata = '0;
            end
        end
    end

    csh_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
            rmw_reg      <= 1'b0;
            done         <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                na_gain_reg[i]   <= csh_pkg::UNITY_GAIN;
                na_shift_reg[i]  <= '0;
                na_tshift_reg[i] <= '0;
            end
            for (int i = 0; i < GE_CHANNELS; i++)
            begin
                ge_gain_reg[i]  <= csh_pkg::UNITY_GAIN;
                ge_shift_reg[i] <= '0;
            end
        end
        else
        begin
            done <= cmd.wr;
            if (cmd.clear_step && !clr_done_reg)
            begin
                if (clr_reg == AW'(STORE_DEPTH - 1))
                begin
                    clr_done_reg <= 1'b1;
                end
                else
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
            end
            if (cmd.capture)
            begin
                rmw_reg <= 1'b0;
            end
            if (cmd.sum || (cmd.mul && !stat.needs_store))
            begin
                rmw_reg <= stat.needs_store && op_reg != csh_pkg::OP_READ;
            end
            if (cmd.wr && op_reg == csh_pkg::OP_LOAD)
            begin
                case (tsel_reg)
                    csh_pkg::TSEL_NA_GAIN:
                        if (na_ok) na_gain_reg[ch_reg[CHW-1:0]] <= cal_reg[15:0];
                    csh_pkg::TSEL_NA_SHIFT:
                        if (na_ok) na_shift_reg[ch_reg[CHW-1:0]] <= cal_reg;
                    csh_pkg::TSEL_NA_TSHIFT:
                        if (na_ok) na_tshift_reg[ch_reg[CHW-1:0]] <= cal_reg;
                    csh_pkg::TSEL_GE_GAIN:
                        if (ge_ok) ge_gain_reg[ch_reg[GCHW-1:0]] <= cal_reg[15:0];
                    csh_pkg::TSEL_GE_SHIFT:
                        if (ge_ok) ge_shift_reg[ch_reg[GCHW-1:0]] <= cal_reg;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            kind_reg <= kind;
            ch_reg   <= channel;
            bidx_reg <= bin_index;
            tsel_reg <= table_select;
            cal_reg  <= cal_value;
            last_reg <= event_last;
            v_reg    <= (25'(signed'({1'b0, raw_value})) <<< 8) + 25'(dither);
            gain_reg <= (kind == csh_pkg::KIND_GE)
                        ? ge_gain_reg[channel[GCHW-1:0]]
                        : na_gain_reg[channel[CHW-1:0]];
            case (kind)
                csh_pkg::KIND_NEW_T: shift_reg <= na_tshift_reg[channel[CHW-1:0]];
                csh_pkg::KIND_GE:    shift_reg <= ge_shift_reg[channel[GCHW-1:0]];
                default:             shift_reg <= na_shift_reg[channel[CHW-1:0]];
            endcase
        end
        if (cmd.mul)
        begin
            prod_reg <= 42'(v_reg) * 42'(signed'({1'b0, gain_reg}));
        end
        if (!cmd.mul)
        begin
            t_reg <= t_comb;
        end
        if (cmd.sum)
        begin
            if (op_reg == csh_pkg::OP_COUNT)
            begin
                bin_reg  <= bin_bad ? 12'd0 : q[11:0];
                st_reg   <= bin_bad ? csh_pkg::ST_CLIPPED : csh_pkg::ST_COUNTED;
                addr_reg <= base + (bin_bad ? AW'(0) : AW'(q[14:0]));
            end
            else
            begin
                bin_reg  <= bidx_reg;
                st_reg   <= (op_reg == csh_pkg::OP_READ) ? csh_pkg::ST_READ
                                                         : csh_pkg::ST_DONE;
                addr_reg <= base + AW'(bidx_reg);
            end
        end
        if (cmd.mul && !stat.needs_store)
        begin
            bin_reg <= '0;
            if (op_reg == csh_pkg::OP_LOAD
                && ((tsel_reg <= csh_pkg::TSEL_NA_TSHIFT && na_ok)
                    || ((tsel_reg == csh_pkg::TSEL_GE_GAIN
                         || tsel_reg == csh_pkg::TSEL_GE_SHIFT) && ge_ok)))
            begin
                st_reg <= csh_pkg::ST_DONE;
            end
            else
            begin
                st_reg <= csh_pkg::ST_IGNORED;
            end
        end
        if (cmd.wr)
        begin
            status         <= st_reg;
            kind_out       <= kind_reg;
            channel_out    <= ch_reg;
            bin_out        <= bin_reg;
            event_last_out <= last_reg;
            if (!rmw_reg && op_reg != csh_pkg::OP_READ)
            begin
                count_out <= '0;
            end
            else if (op_reg == csh_pkg::OP_COUNT)
            begin
                count_out <= rdata + 32'd1;
            end
            else if (op_reg == csh_pkg::OP_READ && st_reg == csh_pkg::ST_READ)
            begin
                count_out <= rdata;
            end
            else
            begin
                count_out <= '0;
            end
        end
    end

endmodule

FILE: design/csh_checker.sv
// ----------------------------------------------------------------------------
// csh_checker
// Port-level checks on the histogrammer, bound to the top level.
// ----------------------------------------------------------------------------
module csh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [11:0] bin_out,
    input logic [31:0] count_out
);

    // An accepted transaction makes the block busy at once.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    // A result is shown only just after the block was busy with a transaction.
    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    // Done is a single-cycle strobe.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Ignored and clipped results carry bin zero.
    a_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == csh_pkg::ST_CLIPPED || status == csh_pkg::ST_IGNORED))
        |-> (bin_out == 12'd0))
        else $error("ignored or clipped result with a non-zero bin");

    // An ignored transaction reports a zero count.
    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == csh_pkg::ST_IGNORED) |-> (count_out == 32'd0))
        else $error("ignored result with a non-zero count");

endmodule

bind calibrated_spectrum_histogrammer_unit csh_checker u_csh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .bin_out   (bin_out),
    .count_out (count_out)
);
